// ===== sv/gbtd_pkg.sv =====
// Shared types, register addresses and the prescaler threshold table of the timer.
package gbtd_pkg;

  // Word kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // Register map.
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  localparam int unsigned ACC_W         = 11;
  localparam logic [7:0]  TICK_TSTATES  = 8'd4;
  localparam int unsigned TAC_ENABLE_BIT = 2;
  localparam logic [7:0]  UNMAPPED_DATA = 8'hFF;

  // One input word.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } result_t;

  // Prescaler threshold in T-states, selected by control bits 1:0.
  function automatic logic [ACC_W-1:0] threshold(input logic [1:0] sel);
    logic [ACC_W-1:0] thr;
    case (sel)
      2'd0:    thr = ACC_W'(1024);
      2'd1:    thr = ACC_W'(16);
      2'd2:    thr = ACC_W'(64);
      default: thr = ACC_W'(256);
    endcase
    return thr;
  endfunction

endpackage

// ===== sv/gbtd_timer.sv =====
// Timer register file and the single-pass update for one word.
module gbtd_timer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  gbtd_pkg::item_t item_i,
  output gbtd_pkg::result_t res_o
);
  import gbtd_pkg::*;

  logic [7:0]       div_q, div_d;
  logic [7:0]       phase_q, phase_d;
  logic [7:0]       tima_q, tima_d;
  logic [7:0]       tma_q, tma_d;
  logic [7:0]       tac_q, tac_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  logic [7:0]       phase_inc;
  logic [ACC_W-1:0] acc_inc;
  logic [ACC_W-1:0] thr;
  logic             enabled;

  assign phase_inc = phase_q + TICK_TSTATES;
  assign acc_inc   = acc_q + ACC_W'(TICK_TSTATES);
  assign thr       = threshold(tac_q[1:0]);
  assign enabled   = tac_q[TAC_ENABLE_BIT];

  // Next state and result for the word in the input register.
  always_comb begin
    div_d   = div_q;
    phase_d = phase_q;
    tima_d  = tima_q;
    tma_d   = tma_q;
    tac_d   = tac_q;
    acc_d   = acc_q;
    res_o   = '0;
    if (fire_i) begin
      case (item_i.kind)
        KIND_TICK: begin
          phase_d = phase_inc;
          if (phase_inc == 8'd0) begin
            div_d = div_q + 8'd1;
          end
          if (enabled) begin
            acc_d = acc_inc;
            if (acc_inc >= thr) begin
              acc_d = acc_inc - thr;
              if (tima_q == 8'hFF) begin
                tima_d          = tma_q;
                res_o.timer_irq = 1'b1;
              end else begin
                tima_d = tima_q + 8'd1;
              end
            end
          end
        end
        KIND_WRITE: begin
          unique case (item_i.address)
            ADDR_DIV:  div_d  = 8'd0;
            ADDR_TIMA: tima_d = item_i.write_data;
            ADDR_TMA:  tma_d  = item_i.write_data;
            ADDR_TAC:  tac_d  = item_i.write_data;
            default:   ;
          endcase
        end
        KIND_READ: begin
          unique case (item_i.address)
            ADDR_DIV:  res_o.read_data = div_q;
            ADDR_TIMA: res_o.read_data = tima_q;
            ADDR_TMA:  res_o.read_data = tma_q;
            ADDR_TAC:  res_o.read_data = tac_q;
            default:   res_o.read_data = UNMAPPED_DATA;
          endcase
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= '0;
      phase_q <= '0;
      tima_q  <= '0;
      tma_q   <= '0;
      tac_q   <= '0;
      acc_q   <= '0;
    end else begin
      div_q   <= div_d;
      phase_q <= phase_d;
      tima_q  <= tima_d;
      tma_q   <= tma_d;
      tac_q   <= tac_d;
      acc_q   <= acc_d;
    end
  end

  // An overflow reloads the counter from the modulo register.
  a_irq_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.timer_irq) |=> (tima_q == $past(tma_q)))
    else $error("counter not reloaded after overflow");

  // With the timer disabled a tick leaves the prescaler and counter alone.
  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.kind == KIND_TICK && !enabled) |=> ($stable(acc_q) && $stable(tima_q)))
    else $error("disabled timer advanced");

  // The phase counter moves only on ticks.
  a_phase_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && item_i.kind == KIND_TICK) |=> $stable(phase_q))
    else $error("phase counter moved without a tick");

endmodule

// ===== sv/gameboy_timer_divider_unit.sv =====
// Top level: input register, timer update and result register with valid/stall handshakes.
// An accepted word waits in the input register; its result is loaded into the result register once that is free.
// Throughput: one word per cycle while the output is not stalled; the timer state updates in a single pass per word.
// While a result waits under stall, one more word is taken into the input register.
// Reset (rst_ni low, asynchronous) clears all timer registers and both valid flags.
module gameboy_timer_divider_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        timer_irq_o
);
  import gbtd_pkg::*;

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t res;
  logic    out_free;
  logic    fire;
  logic    in_take;

  // The result register can load when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{kind: kind_e'(kind_i), address: address_i, write_data: write_data_i};
    end
  end

  gbtd_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_res_q.read_data;
  assign timer_irq_o = out_res_q.timer_irq;

  // A word in the input register is never lost while the output is blocked.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("input word dropped under stall");

  // A drained result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated");

  // Stall is only raised with a word waiting in the input register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("spurious input stall");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the timer unit: directed table, random words and a scoreboard.
module testbench;
  import gbtd_pkg::*;

  // Run limits and pacing.
  localparam int RANDOM_WORDS   = 425;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_AFTER     = 120;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  // The kind code that the block must treat as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Prescaler selections held in control bits 1:0.
  localparam logic [1:0] SEL_T1024 = 2'd0;
  localparam logic [1:0] SEL_T16   = 2'd1;
  localparam logic [1:0] SEL_T64   = 2'd2;
  localparam logic [1:0] SEL_T256  = 2'd3;

  // Receiver stall patterns.
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_TOGGLE = 3;

  // One planned input word, with an optional hand-written expectation.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        fixed;
    logic [7:0]  rd;
    logic        irq;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [15:0] address_i;
  logic [7:0]  write_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic        timer_irq_o;

  // Predicted timer state.
  logic [7:0]       m_div;
  logic [7:0]       m_phase;
  logic [7:0]       m_count;
  logic [7:0]       m_mod;
  logic [7:0]       m_ctrl;
  logic [ACC_W-1:0] m_acc;

  stim_t   stim_plan[$];
  stim_t   directed_rows [0:24];
  result_t pending_results[$];
  int      words_sent = 0;
  int      results_checked = 0;
  int      failures = 0;
  int      overflows_predicted = 0;
  int      kind_seen [4] = '{0, 0, 0, 0};
  bit      hold_done = 1'b0;

  gameboy_timer_divider_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .timer_irq_o  (timer_irq_o)
  );

  always #1 clk_i = ~clk_i;

  // Advance the predicted timer by one word and return the result it should give.
  function automatic result_t predict_word(input logic [1:0] kind, input logic [15:0] addr,
                                           input logic [7:0] data);
    result_t          res;
    logic [ACC_W-1:0] limit;
    res = '0;
    case (kind)
      KIND_TICK: begin
        m_phase = m_phase + TICK_TSTATES;
        if (m_phase == 8'd0) m_div = m_div + 8'd1;
        if (m_ctrl[TAC_ENABLE_BIT]) begin
          case (m_ctrl[1:0])
            SEL_T1024: limit = ACC_W'(1024);
            SEL_T16:   limit = ACC_W'(16);
            SEL_T64:   limit = ACC_W'(64);
            default:   limit = ACC_W'(256);
          endcase
          m_acc = m_acc + ACC_W'(TICK_TSTATES);
          // At most one step per tick, even if the threshold was lowered mid-count.
          if (m_acc >= limit) begin
            m_acc = m_acc - limit;
            if (m_count == 8'hFF) begin
              m_count = m_mod;
              res.timer_irq = 1'b1;
            end else begin
              m_count = m_count + 8'd1;
            end
          end
        end
      end
      KIND_WRITE: begin
        case (addr)
          ADDR_DIV:  m_div = 8'd0;
          ADDR_TIMA: m_count = data;
          ADDR_TMA:  m_mod = data;
          ADDR_TAC:  m_ctrl = data;
          default:   ;
        endcase
      end
      KIND_READ: begin
        case (addr)
          ADDR_DIV:  res.read_data = m_div;
          ADDR_TIMA: res.read_data = m_count;
          ADDR_TMA:  res.read_data = m_mod;
          ADDR_TAC:  res.read_data = m_ctrl;
          default:   res.read_data = UNMAPPED_DATA;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  // An address outside the register map, sometimes close to it.
  function automatic logic [15:0] pick_unmapped();
    logic [15:0] a;
    a = ($urandom_range(2) == 0) ? (16'hFF00 | 16'($urandom_range(15)))
                                 : 16'($urandom_range(16'hFFFF));
    if (a >= ADDR_DIV && a <= ADDR_TAC) a = a ^ 16'h0100;
    return a;
  endfunction

  // Random words: runs of ticks between register traffic, plus some noise.
  task automatic build_random_plan();
    stim_t w;
    int    pick;
    int    run;
    int    n;
    n = 0;
    while (n < RANDOM_WORDS) begin
      w = '0;
      w.addr = 16'($urandom_range(16'hFFFF));
      w.data = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 50) begin
        w.kind = KIND_TICK;
        run = $urandom_range(1, 12);
        repeat (run) begin
          w.addr = 16'($urandom_range(16'hFFFF));
          w.data = 8'($urandom_range(255));
          stim_plan.push_back(w);
        end
        n += run;
      end else begin
        if (pick < 92) begin
          w.kind = (pick < 72) ? KIND_WRITE : KIND_READ;
          case ($urandom_range(3))
            0:       w.addr = ADDR_DIV;
            1:       w.addr = ADDR_TIMA;
            2:       w.addr = ADDR_TMA;
            default: w.addr = ADDR_TAC;
          endcase
          // Keep the timer mostly running and the counter near its top.
          if (w.addr == ADDR_TAC) begin
            if ($urandom_range(4) != 0) w.data[TAC_ENABLE_BIT] = 1'b1;
            if ($urandom_range(9) < 4) w.data[1:0] = SEL_T16;
          end else if (w.addr == ADDR_TIMA && $urandom_range(1) == 0) begin
            w.data = 8'hF0 | 8'($urandom_range(15));
          end
        end else if (pick < 97) begin
          w.kind = ($urandom_range(1) == 0) ? KIND_WRITE : KIND_READ;
          w.addr = pick_unmapped();
        end else begin
          w.kind = KIND_UNUSED;
        end
        stim_plan.push_back(w);
        n++;
      end
    end
  endtask

  // Main sequence: plan, reset, send every word, drain and report.
  initial begin
    stim_t   w;
    result_t pred;
    int      burst_left;
    int      gap;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_TICK;
    address_i    = '0;
    write_data_i = '0;
    m_div   = '0;
    m_phase = '0;
    m_count = '0;
    m_mod   = '0;
    m_ctrl  = '0;
    m_acc   = '0;
    burst_left = 0;

    // Directed table: reset values, unmapped and unused words, overflow with a
    // lowered threshold, disabled timer and a divider clear.
    directed_rows = '{
      '{KIND_READ,   ADDR_DIV,  8'h00, 1'b1, 8'h00, 1'b0},
      '{KIND_READ,   ADDR_TIMA, 8'h00, 1'b1, 8'h00, 1'b0},
      '{KIND_READ,   ADDR_TMA,  8'h00, 1'b1, 8'h00, 1'b0},
      '{KIND_READ,   ADDR_TAC,  8'h00, 1'b1, 8'h00, 1'b0},
      '{KIND_READ,   16'h0000,  8'h00, 1'b1, 8'hFF, 1'b0},
      '{KIND_READ,   16'hFFFF,  8'hFF, 1'b1, 8'hFF, 1'b0},
      '{KIND_UNUSED, 16'hFFFF,  8'hFF, 1'b1, 8'h00, 1'b0},
      '{KIND_WRITE,  ADDR_TMA,  8'hA5, 1'b0, 8'h00, 1'b0},
      '{KIND_WRITE,  ADDR_TIMA, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{KIND_WRITE,  ADDR_TAC,  8'h06, 1'b0, 8'h00, 1'b0},
      '{KIND_TICK,   16'h0000,  8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_TICK,   16'hFFFF,  8'hFF, 1'b0, 8'h00, 1'b0},
      '{KIND_TICK,   16'h0000,  8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_TICK,   16'hFFFF,  8'hFF, 1'b0, 8'h00, 1'b0},
      '{KIND_TICK,   16'h0000,  8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_WRITE,  ADDR_TAC,  8'h05, 1'b0, 8'h00, 1'b0},
      '{KIND_TICK,   16'h0000,  8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_READ,   ADDR_TIMA, 8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_WRITE,  ADDR_TAC,  8'hFB, 1'b0, 8'h00, 1'b0},
      '{KIND_TICK,   16'h0000,  8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_WRITE,  ADDR_DIV,  8'h5A, 1'b0, 8'h00, 1'b0},
      '{KIND_WRITE,  16'h0000,  8'hFF, 1'b0, 8'h00, 1'b0},
      '{KIND_READ,   ADDR_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_READ,   ADDR_TAC,  8'h00, 1'b0, 8'h00, 1'b0},
      '{KIND_WRITE,  ADDR_TAC,  8'hFF, 1'b0, 8'h00, 1'b0}
    };
    foreach (directed_rows[i]) stim_plan.push_back(directed_rows[i]);
    build_random_plan();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender: bursts of random length separated by random gaps.
    foreach (stim_plan[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      burst_left--;
      w = stim_plan[i];
      @(negedge clk_i);
      in_valid_i   <= 1'b1;
      kind_i       <= w.kind;
      address_i    <= w.addr;
      write_data_i <= w.data;
      do @(posedge clk_i); while (in_stall_o);
      pred = predict_word(w.kind, w.addr, w.data);
      if (w.fixed) begin
        pred.read_data = w.rd;
        pred.timer_irq = w.irq;
      end
      if (pred.timer_irq) overflows_predicted++;
      kind_seen[w.kind]++;
      pending_results.push_back(pred);
      words_sent++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then allow the pipeline to settle.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d ticks, %0d writes, %0d reads, %0d unused kind).",
             words_sent, kind_seen[KIND_TICK], kind_seen[KIND_WRITE], kind_seen[KIND_READ],
             kind_seen[KIND_UNUSED]);
    $display("Checked %0d results, %0d overflows, %0d failures; one hold-off of %0d cycles.",
             results_checked, overflows_predicted, failures, HOLD_CYCLES);
    if (failures == 0) begin
      $display("** gameboy_timer_divider_unit: PASSED **");
    end else begin
      $display("** gameboy_timer_divider_unit: FAILED **");
    end
    $finish;
  end

  // Receiver: stall patterns of random length, and one long hold-off to fill the block.
  initial begin
    int mode;
    int span;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && words_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end
      mode = $urandom_range(STALL_TOGGLE);
      span = $urandom_range(5, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(99) < 30);
          STALL_HEAVY: out_stall_i <= ($urandom_range(99) < 70);
          default:     out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Scoreboard: each accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("Unexpected result word: read_data=%02h timer_irq=%0b",
                   read_data_o, timer_irq_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (read_data_o !== want.read_data || timer_irq_o !== want.timer_irq) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("Result %0d mismatch: read_data exp %02h got %02h, %s %0b got %0b",
                     results_checked, want.read_data, read_data_o, "timer_irq exp",
                     want.timer_irq, timer_irq_o);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
    $display("** gameboy_timer_divider_unit: FAILED **");
    $finish;
  end

endmodule

// ===== gameboy_timer_divider_unit.f =====
sv/gbtd_pkg.sv
sv/gbtd_timer.sv
sv/gameboy_timer_divider_unit.sv
tb/sv/testbench.sv
